// ----- rtl/pnm_pkg.sv -----
// pnm_pkg: shared types and constants of the pnm decoder
// phase and sequencer enums, queue entry and result structs, character codes
// no dependencies
package pnm_pkg;

    localparam int QDEPTH = 2;
    localparam int DIVN   = 29;

    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_1    = 8'h31;
    localparam logic [7:0] CH_4    = 8'h34;
    localparam logic [7:0] CH_9    = 8'h39;

    localparam logic [1:0] FMT_P1 = 2'd0;
    localparam logic [1:0] FMT_P2 = 2'd1;
    localparam logic [1:0] FMT_P3 = 2'd2;
    localparam logic [1:0] FMT_P4 = 2'd3;

    localparam logic [2:0] E_MAGIC  = 3'd0;
    localparam logic [2:0] E_CHAR   = 3'd1;
    localparam logic [2:0] E_BIGNUM = 3'd2;
    localparam logic [2:0] E_SIZE   = 3'd3;
    localparam logic [2:0] E_MAXVAL = 3'd4;
    localparam logic [2:0] E_TRUNC  = 3'd5;

    typedef enum logic [1:0] {
        K_HDR = 2'd0,
        K_PIX = 2'd1,
        K_ERR = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        PH_WAIT_P, PH_WAIT_D, PH_HEADER, PH_AFTER_CR, PH_BODY, PH_DONE, PH_ERROR
    } t_phase;

    typedef enum logic [2:0] {
        B_IDLE, B_EXEC, B_FIN, B_DIV, B_TAIL, B_BITS
    } t_bst;

    typedef struct packed {
        logic [7:0] data;
        logic       eof;
        logic       is_digit;
        logic       is_space;
        logic       is_hash;
        logic       is_p;
        logic       is_fmt;
        logic       is_lf;
        logic       is_cr;
        logic [3:0] dval;
        logic [1:0] fmt;
    } t_item;

    typedef struct packed {
        t_kind       kind;
        logic [2:0]  err;
        logic [16:0] w;
        logic [16:0] h;
        logic [1:0]  ch;
        logic [16:0] col;
        logic [16:0] row;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
    } t_res;

endpackage

// ----- rtl/pnm_if.sv -----
// pnm_in_if and pnm_out_if: valid/ready channels of the pnm decoder
// payload widths are fixed by the file format fields
interface pnm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_file;
    modport source (output valid, data_byte, end_of_file, input ready);
    modport sink   (input valid, data_byte, end_of_file, output ready);
endinterface

interface pnm_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [2:0]  error_code;
    logic [16:0] image_width;
    logic [16:0] image_height;
    logic [1:0]  channel_count;
    logic [16:0] pixel_column;
    logic [16:0] pixel_row;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last_result;
    modport source (output valid, result_kind, error_code, image_width, image_height,
                    channel_count, pixel_column, pixel_row, red, green, blue, last_result,
                    input ready);
    modport sink   (input valid, result_kind, error_code, image_width, image_height,
                    channel_count, pixel_column, pixel_row, red, green, blue, last_result,
                    output ready);
endinterface

// ----- rtl/pnm_front.sv -----
// pnm_front: accepts input words and classifies each byte
// depends on pnm_pkg and pnm_in_if
module pnm_front (
    pnm_in_if.sink          i_in,
    input  logic            i_full,
    output logic            o_push,
    output pnm_pkg::t_item  o_item
);
    logic [7:0] b;

    assign b            = i_in.data_byte;
    assign i_in.ready   = !i_full;
    assign o_push       = i_in.valid && !i_full;

    always_comb begin
        o_item          = '0;
        o_item.data     = b;
        o_item.eof      = i_in.end_of_file;
        o_item.is_digit = (b >= pnm_pkg::CH_0) && (b <= pnm_pkg::CH_9);
        o_item.is_space = (b == 8'h20) || ((b >= 8'h09) && (b <= pnm_pkg::CH_CR));
        o_item.is_hash  = (b == pnm_pkg::CH_HASH);
        o_item.is_p     = (b == pnm_pkg::CH_P);
        o_item.is_fmt   = (b >= pnm_pkg::CH_1) && (b <= pnm_pkg::CH_4);
        o_item.is_lf    = (b == pnm_pkg::CH_LF);
        o_item.is_cr    = (b == pnm_pkg::CH_CR);
        o_item.dval     = 4'(b - pnm_pkg::CH_0);
        o_item.fmt      = 2'(b - pnm_pkg::CH_1);
    end
endmodule

// ----- rtl/pnm_queue.sv -----
// pnm_queue: short queue between the classifier and the sequencer
// depends on pnm_pkg
module pnm_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pnm_pkg::t_item i_item,
    output logic           o_full,
    output logic           o_valid,
    output pnm_pkg::t_item o_item,
    input  logic           i_pop
);
    localparam int PW = $clog2(pnm_pkg::QDEPTH);

    pnm_pkg::t_item r_mem [pnm_pkg::QDEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [PW:0]    r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(pnm_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end
endmodule

// ----- rtl/pnm_div.sv -----
// pnm_div: restoring divider, one quotient bit per cycle
// gives the low byte of the quotient; depends on pnm_pkg
module pnm_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [pnm_pkg::DIVN-1:0] i_num,
    input  logic [7:0]               i_den,
    output logic                     o_busy,
    output logic [7:0]               o_q
);
    logic                     r_busy;
    logic [4:0]               r_cnt;
    logic [7:0]               r_rem;
    logic [7:0]               r_den;
    logic [pnm_pkg::DIVN-1:0] r_q;
    logic [8:0]               t;
    logic                     ge;

    assign t      = {r_rem, r_q[pnm_pkg::DIVN-1]};
    assign ge     = (t >= {1'b0, r_den});
    assign o_busy = r_busy;
    assign o_q    = r_q[7:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 5'(pnm_pkg::DIVN - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? 8'(t - {1'b0, r_den}) : t[7:0];
            r_q   <= {r_q[pnm_pkg::DIVN-2:0], ge};
        end
    end
endmodule

// ----- rtl/pnm_back.sv -----
// pnm_back: sequencer that parses header and body and produces results
// depends on pnm_pkg and pnm_div
module pnm_back #(
    parameter int MAX_DIM      = 100000,
    parameter int NUMBER_LIMIT = 1048576
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  pnm_pkg::t_item i_item,
    output logic           o_pop,
    output logic           o_emit,
    output logic           o_last,
    output pnm_pkg::t_res  o_res,
    input  logic           i_go
);
    pnm_pkg::t_bst   r_st, n_st;
    pnm_pkg::t_phase r_ph, n_ph;
    pnm_pkg::t_item  r_it, n_it;
    logic [1:0]  r_fmt, n_fmt, r_hfc, n_hfc, r_comp, n_comp;
    logic [16:0] r_w, n_w, r_h, n_h, r_col, n_col, r_row, n_row;
    logic [7:0]  r_max, n_max, r_hr, n_hr, r_hg, n_hg;
    logic [20:0] r_acc, n_acc;
    logic        r_innum, n_innum, r_incom, n_incom, r_washdr, n_washdr;
    logic [2:0]  r_k, n_k;

    logic        div_start, div_busy;
    logic [7:0]  div_q;
    logic        tail, pix, done, emit;
    logic [7:0]  pr, pg, pb;
    logic [24:0] acc10;
    logic [17:0] c1, r1;
    logic [7:0]  gray;

    pnm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start && i_go),
        .i_num   ({r_acc, 8'd0} - 29'(r_acc)),
        .i_den   (r_max),
        .o_busy  (div_busy),
        .o_q     (div_q)
    );

    assign acc10 = 25'(r_acc) * 25'd10 + 25'(r_it.dval);
    assign o_emit = emit;
    assign o_last = done;

    always_comb begin
        n_st = r_st; n_ph = r_ph; n_it = r_it; n_fmt = r_fmt; n_hfc = r_hfc;
        n_comp = r_comp; n_w = r_w; n_h = r_h; n_col = r_col; n_row = r_row;
        n_max = r_max; n_hr = r_hr; n_hg = r_hg; n_acc = r_acc; n_innum = r_innum;
        n_incom = r_incom; n_washdr = r_washdr; n_k = r_k;
        div_start = 1'b0; o_pop = 1'b0; tail = 1'b0; pix = 1'b0; done = 1'b0;
        emit = 1'b0; pr = '0; pg = '0; pb = '0; o_res = '0;
        c1 = '0; r1 = '0; gray = '0;
        case (r_st)
            pnm_pkg::B_IDLE: begin
                if (i_valid) begin
                    o_pop = 1'b1;
                    n_it  = i_item;
                    n_st  = pnm_pkg::B_EXEC;
                end
            end
            pnm_pkg::B_EXEC: begin
                if (r_it.eof) begin
                    n_st = ((r_ph == pnm_pkg::PH_HEADER || r_ph == pnm_pkg::PH_BODY) && r_innum)
                         ? pnm_pkg::B_FIN : pnm_pkg::B_TAIL;
                end else begin
                    case (r_ph)
                        pnm_pkg::PH_WAIT_P: begin
                            done = 1'b1;
                            if (r_it.is_p) n_ph = pnm_pkg::PH_WAIT_D;
                            else begin
                                emit = 1'b1; o_res.kind = pnm_pkg::K_ERR;
                                o_res.err = pnm_pkg::E_MAGIC; n_ph = pnm_pkg::PH_ERROR;
                            end
                        end
                        pnm_pkg::PH_WAIT_D: begin
                            done = 1'b1;
                            if (r_it.is_fmt) begin
                                n_fmt = r_it.fmt; n_ph = pnm_pkg::PH_HEADER;
                            end else begin
                                emit = 1'b1; o_res.kind = pnm_pkg::K_ERR;
                                o_res.err = pnm_pkg::E_MAGIC; n_ph = pnm_pkg::PH_ERROR;
                            end
                        end
                        pnm_pkg::PH_HEADER, pnm_pkg::PH_AFTER_CR, pnm_pkg::PH_BODY: begin
                            if (r_ph == pnm_pkg::PH_AFTER_CR) n_ph = pnm_pkg::PH_BODY;
                            if (r_ph == pnm_pkg::PH_AFTER_CR && r_it.is_lf) done = 1'b1;
                            else if (r_ph != pnm_pkg::PH_HEADER && r_fmt == pnm_pkg::FMT_P4) begin
                                n_st = pnm_pkg::B_BITS; n_k = '0;
                            end else if (r_incom) begin
                                if (r_it.is_lf) n_incom = 1'b0;
                                done = 1'b1;
                            end else if (r_innum) begin
                                if (r_it.is_digit) begin
                                    done = 1'b1;
                                    if (acc10 > 25'(NUMBER_LIMIT)) begin
                                        emit = 1'b1; o_res.kind = pnm_pkg::K_ERR;
                                        o_res.err = pnm_pkg::E_BIGNUM; n_ph = pnm_pkg::PH_ERROR;
                                    end else n_acc = acc10[20:0];
                                end else n_st = pnm_pkg::B_FIN;
                            end else tail = 1'b1;
                        end
                        default: done = 1'b1;
                    endcase
                end
            end
            pnm_pkg::B_FIN: begin
                n_innum  = 1'b0;
                n_washdr = (r_ph == pnm_pkg::PH_HEADER);
                n_st     = pnm_pkg::B_TAIL;
                if (r_ph == pnm_pkg::PH_HEADER) begin
                    o_res.w  = r_w;
                    o_res.h  = r_h;
                    o_res.ch = (r_fmt == pnm_pkg::FMT_P3) ? 2'd3 : 2'd1;
                    if (r_hfc == 2'd2) begin
                        emit = 1'b1;
                        if (r_acc < 21'd1 || r_acc > 21'd255) begin
                            o_res = '0; o_res.kind = pnm_pkg::K_ERR;
                            o_res.err = pnm_pkg::E_MAXVAL; n_ph = pnm_pkg::PH_ERROR;
                        end else begin
                            o_res.kind = pnm_pkg::K_HDR; n_max = r_acc[7:0];
                            n_ph = pnm_pkg::PH_BODY;
                        end
                    end else if (r_acc < 21'd1 || r_acc > 21'(MAX_DIM)) begin
                        emit = 1'b1; o_res = '0; o_res.kind = pnm_pkg::K_ERR;
                        o_res.err = pnm_pkg::E_SIZE; n_ph = pnm_pkg::PH_ERROR;
                    end else if (r_hfc == 2'd0) begin
                        n_w = r_acc[16:0]; n_hfc = 2'd1;
                    end else begin
                        n_h = r_acc[16:0]; o_res.h = r_acc[16:0];
                        if (r_fmt == pnm_pkg::FMT_P1 || r_fmt == pnm_pkg::FMT_P4) begin
                            emit = 1'b1; o_res.kind = pnm_pkg::K_HDR;
                            n_ph = pnm_pkg::PH_BODY;
                        end else n_hfc = 2'd2;
                    end
                end else if (r_fmt == pnm_pkg::FMT_P1) begin
                    gray = (r_acc != '0) ? 8'd0 : 8'd255;
                    pix = 1'b1; pr = gray; pg = gray; pb = gray;
                end else begin
                    div_start = 1'b1;
                    n_st = pnm_pkg::B_DIV;
                end
            end
            pnm_pkg::B_DIV: begin
                if (!div_busy) begin
                    n_st = pnm_pkg::B_TAIL;
                    if (r_fmt == pnm_pkg::FMT_P2) begin
                        pix = 1'b1; pr = div_q; pg = div_q; pb = div_q;
                    end else if (r_comp == 2'd0) begin
                        n_hr = div_q; n_comp = 2'd1;
                    end else if (r_comp == 2'd1) begin
                        n_hg = div_q; n_comp = 2'd2;
                    end else begin
                        n_comp = 2'd0; pix = 1'b1; pr = r_hr; pg = r_hg; pb = div_q;
                    end
                end
            end
            pnm_pkg::B_TAIL: begin
                if (r_it.eof) begin
                    done = 1'b1;
                    if (r_ph != pnm_pkg::PH_DONE && r_ph != pnm_pkg::PH_ERROR) begin
                        emit = 1'b1; o_res.kind = pnm_pkg::K_ERR; o_res.err = pnm_pkg::E_TRUNC;
                    end
                    n_ph = pnm_pkg::PH_WAIT_P; n_fmt = '0; n_w = '0; n_h = '0; n_max = 8'd1;
                    n_acc = '0; n_innum = 1'b0; n_incom = 1'b0; n_hfc = '0; n_col = '0;
                    n_row = '0; n_comp = '0; n_hr = '0; n_hg = '0;
                end else if (r_ph == pnm_pkg::PH_ERROR || r_ph == pnm_pkg::PH_DONE) begin
                    done = 1'b1;
                end else if (r_washdr && r_ph == pnm_pkg::PH_BODY) begin
                    done = 1'b1;
                    if (r_it.is_cr) n_ph = pnm_pkg::PH_AFTER_CR;
                end else tail = 1'b1;
            end
            pnm_pkg::B_BITS: begin
                n_k = r_k + 1'b1;
                c1  = 18'(r_col);
                if (r_col < r_w) begin
                    emit = 1'b1;
                    gray = r_it.data[3'd7 - r_k] ? 8'd0 : 8'd255;
                    o_res.kind = pnm_pkg::K_PIX; o_res.col = r_col; o_res.row = r_row;
                    o_res.r = gray; o_res.g = gray; o_res.b = gray;
                    c1 = 18'(r_col) + 18'd1;
                    n_col = c1[16:0];
                end
                if (r_k == 3'd7) begin
                    done = 1'b1;
                    if (c1 >= 18'(r_w)) begin
                        n_col = '0;
                        r1 = 18'(r_row) + 18'd1;
                        n_row = r1[16:0];
                        if (r1[16:0] >= r_h) n_ph = pnm_pkg::PH_DONE;
                    end
                end
            end
            default: n_st = pnm_pkg::B_IDLE;
        endcase

        if (pix) begin
            emit = 1'b1;
            o_res.kind = pnm_pkg::K_PIX; o_res.col = r_col; o_res.row = r_row;
            o_res.r = pr; o_res.g = pg; o_res.b = pb;
            c1 = 18'(r_col) + 18'd1;
            if (c1 >= 18'(r_w)) begin
                n_col = '0;
                r1 = 18'(r_row) + 18'd1;
                n_row = r1[16:0];
                if (r1[16:0] >= r_h) n_ph = pnm_pkg::PH_DONE;
            end else n_col = c1[16:0];
        end

        if (tail) begin
            done = 1'b1;
            if (r_it.is_hash) n_incom = 1'b1;
            else if (r_it.is_digit) begin
                n_innum = 1'b1; n_acc = 21'(r_it.dval);
            end else if (!r_it.is_space) begin
                emit = 1'b1; o_res.kind = pnm_pkg::K_ERR; o_res.err = pnm_pkg::E_CHAR;
                n_ph = pnm_pkg::PH_ERROR;
            end
        end

        if (done) n_st = pnm_pkg::B_IDLE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= pnm_pkg::B_IDLE; r_ph <= pnm_pkg::PH_WAIT_P; r_it <= '0;
            r_fmt <= '0; r_hfc <= '0; r_comp <= '0; r_w <= '0; r_h <= '0;
            r_col <= '0; r_row <= '0; r_max <= 8'd1; r_hr <= '0; r_hg <= '0;
            r_acc <= '0; r_innum <= 1'b0; r_incom <= 1'b0; r_washdr <= 1'b0; r_k <= '0;
        end else if (i_go) begin
            r_st <= n_st; r_ph <= n_ph; r_it <= n_it; r_fmt <= n_fmt; r_hfc <= n_hfc;
            r_comp <= n_comp; r_w <= n_w; r_h <= n_h; r_col <= n_col; r_row <= n_row;
            r_max <= n_max; r_hr <= n_hr; r_hg <= n_hg; r_acc <= n_acc;
            r_innum <= n_innum; r_incom <= n_incom; r_washdr <= n_washdr; r_k <= n_k;
        end
    end
endmodule

// ----- rtl/pnm_bitmap_graymap_pixmap_decoder.sv -----
// pnm_bitmap_graymap_pixmap_decoder: top level of the pnm p1..p4 decoder
// depends on pnm_pkg, pnm_if, pnm_front, pnm_queue, pnm_back, pnm_div
//
// usage
//   i_in carries one file byte per word, or an end of file marker
//   o_out carries header, pixel and error results, last_result on the
//   final result of each input word
//   a classifier takes words into a two entry queue; a sequencer pops
//   one word at a time and runs it to completion
//   a p2 or p3 sample that ends on a byte also passes through the
//   bit-serial divider
//   a p4 byte gives one pixel per cycle while the receiver does not stall
//   a result reaches o_out through a holding register and the output
//   register; it stays in the holding register until the next result or
//   the end of its word
//   when the receiver stalls, the sequencer stops at its next result and
//   the queue fills, after which i_in.ready falls
//   synchronous reset returns the parser to waiting for the magic
module pnm_bitmap_graymap_pixmap_decoder #(
    parameter int MAX_DIM      = 100000,
    parameter int NUMBER_LIMIT = 1048576
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pnm_in_if.sink      i_in,
    pnm_out_if.source   o_out
);
    logic           push, full, q_valid, pop, emit, last_in, go, out_free, move;
    logic           pend_last_eff;
    pnm_pkg::t_item f_item, q_item;
    pnm_pkg::t_res  b_res, r_pend, r_out;
    logic           r_pend_v, r_pend_last, r_out_v, r_out_last;

    pnm_front u_front (.i_in(i_in), .i_full(full), .o_push(push), .o_item(f_item));

    pnm_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_item(f_item),
        .o_full(full), .o_valid(q_valid), .o_item(q_item), .i_pop(pop && go)
    );

    pnm_back #(.MAX_DIM(MAX_DIM), .NUMBER_LIMIT(NUMBER_LIMIT)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .i_item(q_item),
        .o_pop(pop), .o_emit(emit), .o_last(last_in), .o_res(b_res), .i_go(go)
    );

    assign out_free      = !r_out_v || o_out.ready;
    assign pend_last_eff = r_pend_last || (last_in && !emit);
    assign move          = r_pend_v && out_free && (emit || pend_last_eff);
    assign go            = !(emit && r_pend_v && !out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v    <= 1'b0;
            r_pend_last <= 1'b0;
            r_out_v     <= 1'b0;
        end else begin
            if (move) r_out_v <= 1'b1;
            else if (o_out.ready) r_out_v <= 1'b0;
            if (go && emit) begin
                r_pend_v    <= 1'b1;
                r_pend_last <= last_in;
            end else if (move) r_pend_v <= 1'b0;
            else if (last_in && !emit && r_pend_v) r_pend_last <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && emit) r_pend <= b_res;
        if (move) begin
            r_out      <= r_pend;
            r_out_last <= pend_last_eff;
        end
    end

    assign o_out.valid         = r_out_v;
    assign o_out.result_kind   = r_out.kind;
    assign o_out.error_code    = r_out.err;
    assign o_out.image_width   = r_out.w;
    assign o_out.image_height  = r_out.h;
    assign o_out.channel_count = r_out.ch;
    assign o_out.pixel_column  = r_out.col;
    assign o_out.pixel_row     = r_out.row;
    assign o_out.red           = r_out.r;
    assign o_out.green         = r_out.g;
    assign o_out.blue          = r_out.b;
    assign o_out.last_result   = r_out_last;
endmodule

// ----- rtl/pnm_chk.sv -----
// pnm_chk: port level checks on the pnm decoder results
// bound to pnm_bitmap_graymap_pixmap_decoder; depends on pnm_pkg
module pnm_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [1:0]  i_kind,
    input logic [2:0]  i_err,
    input logic [1:0]  i_ch,
    input logic        i_last
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_kind) && $stable(i_last))
        else $error("result changed while stalled");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind == pnm_pkg::K_ERR |-> i_last)
        else $error("error result not last");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind == pnm_pkg::K_ERR |-> i_err <= pnm_pkg::E_TRUNC)
        else $error("error code out of range");

    a_hdr_ch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind == pnm_pkg::K_HDR |-> i_ch == 2'd1 || i_ch == 2'd3)
        else $error("bad channel count");
endmodule

bind pnm_bitmap_graymap_pixmap_decoder pnm_chk u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_out.valid),
    .i_ready (o_out.ready),
    .i_kind  (o_out.result_kind),
    .i_err   (o_out.error_code),
    .i_ch    (o_out.channel_count),
    .i_last  (o_out.last_result)
);

// ----- tb/tb_pnm_if.sv -----
// tb_pnm_if: no extra interfaces needed, the testbench uses the rtl channels
// pnm_in_if and pnm_out_if from rtl/pnm_if.sv; this file holds the shared
// result record type used by the testbench top
package tb_pnm_types;
    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  err;
        logic [16:0] w;
        logic [16:0] h;
        logic [1:0]  ch;
        logic [16:0] col;
        logic [16:0] row;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic        last;
    } t_expect;
endpackage

// ----- tb/tb_pnm_bitmap_graymap_pixmap_decoder.sv -----
// tb_pnm_bitmap_graymap_pixmap_decoder: feeds pnm files byte by byte into the decoder
// and checks every header, pixel and error word against an in-bench parser model
// depends on pnm_pkg, pnm_if, tb_pnm_types and the decoder rtl
module tb_pnm_bitmap_graymap_pixmap_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXD = 100000;
    localparam int NLIM = 1048576;
    localparam int CYCLE_LIMIT = 2000000;

    logic i_clk, i_rst_n;
    pnm_in_if  in_ch();
    pnm_out_if out_ch();

    pnm_bitmap_graymap_pixmap_decoder dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // parser model state
    pnm_pkg::t_phase pm_phase;
    logic [1:0]  pm_fmt;
    logic [16:0] pm_w, pm_h, pm_col, pm_row;
    logic [7:0]  pm_max, pm_hr, pm_hg;
    logic [20:0] pm_acc;
    logic pm_innum, pm_incom;
    logic [1:0] pm_nf, pm_comp;

    tb_pnm_types::t_expect pixel_words[$];
    logic [8:0] byte_queue[$];
    int mismatches, received;
    int produced;
    int added;
    logic stim_done;

    function automatic void pm_clear();
        pm_phase = pnm_pkg::PH_WAIT_P; pm_fmt = pnm_pkg::FMT_P1; pm_w = '0; pm_h = '0;
        pm_max = 8'd1; pm_acc = '0; pm_innum = 1'b0; pm_incom = 1'b0; pm_nf = '0;
        pm_col = '0; pm_row = '0; pm_comp = '0; pm_hr = '0; pm_hg = '0;
    endfunction

    function automatic void push_word(logic [1:0] k, logic [2:0] e, logic [16:0] w,
                                      logic [16:0] h, logic [1:0] ch, logic [16:0] c,
                                      logic [16:0] r, logic [7:0] rd, logic [7:0] gr,
                                      logic [7:0] bl);
        tb_pnm_types::t_expect x;
        if (produced >= 8) return;
        x = '{kind: k, err: e, w: w, h: h, ch: ch, col: c, row: r, r: rd, g: gr, b: bl,
              last: 1'b0};
        pixel_words.push_back(x);
        produced++;
    endfunction

    function automatic void pm_error(logic [2:0] code);
        pm_phase = pnm_pkg::PH_ERROR;
        push_word(pnm_pkg::K_ERR, code, '0, '0, '0, '0, '0, '0, '0, '0);
    endfunction

    function automatic void pm_header();
        push_word(pnm_pkg::K_HDR, '0, pm_w, pm_h,
                  (pm_fmt == pnm_pkg::FMT_P3) ? 2'd3 : 2'd1, '0, '0, '0, '0, '0);
        pm_phase = pnm_pkg::PH_BODY;
    endfunction

    function automatic void pm_row_end();
        pm_col = '0;
        pm_row = pm_row + 17'd1;
        if (pm_row >= pm_h) pm_phase = pnm_pkg::PH_DONE;
    endfunction

    function automatic void pm_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        push_word(pnm_pkg::K_PIX, '0, '0, '0, '0, pm_col, pm_row, r, g, b);
        pm_col = pm_col + 17'd1;
        if (pm_col >= pm_w) pm_row_end();
    endfunction

    function automatic logic [7:0] pm_scale(logic [20:0] v);
        logic [31:0] m, p;
        m = (pm_max == '0) ? 32'd1 : 32'(pm_max);
        p = (32'(v) * 32'd255) / m;
        return p[7:0];
    endfunction

    function automatic void pm_finish();
        logic [20:0] v;
        logic [7:0] s;
        v = pm_acc;
        pm_innum = 1'b0;
        if (pm_phase == pnm_pkg::PH_HEADER) begin
            if (pm_nf == 2'd0) begin
                if (v < 1 || v > MAXD) begin pm_error(pnm_pkg::E_SIZE); return; end
                pm_w = v[16:0]; pm_nf = 2'd1;
            end else if (pm_nf == 2'd1) begin
                if (v < 1 || v > MAXD) begin pm_error(pnm_pkg::E_SIZE); return; end
                pm_h = v[16:0];
                if (pm_fmt == pnm_pkg::FMT_P1 || pm_fmt == pnm_pkg::FMT_P4) pm_header();
                else pm_nf = 2'd2;
            end else begin
                if (v < 1 || v > 255) begin pm_error(pnm_pkg::E_MAXVAL); return; end
                pm_max = v[7:0];
                pm_header();
            end
            return;
        end
        if (pm_fmt == pnm_pkg::FMT_P1) begin
            s = (v != '0) ? 8'd0 : 8'd255;
            pm_pixel(s, s, s);
        end else if (pm_fmt == pnm_pkg::FMT_P2) begin
            s = pm_scale(v);
            pm_pixel(s, s, s);
        end else begin
            s = pm_scale(v);
            if (pm_comp == 2'd0) begin pm_hr = s; pm_comp = 2'd1; end
            else if (pm_comp == 2'd1) begin pm_hg = s; pm_comp = 2'd2; end
            else begin pm_comp = 2'd0; pm_pixel(pm_hr, pm_hg, s); end
        end
    endfunction

    function automatic void pm_text(logic [7:0] b);
        logic dig, was_hdr, sp;
        logic [24:0] a;
        dig = (b >= pnm_pkg::CH_0 && b <= pnm_pkg::CH_9);
        sp = (b == 8'h20 || (b >= 8'h09 && b <= 8'h0D));
        if (pm_incom) begin
            if (b == pnm_pkg::CH_LF) pm_incom = 1'b0;
            return;
        end
        if (pm_innum) begin
            if (dig) begin
                a = 25'(pm_acc) * 25'd10 + 25'(b - pnm_pkg::CH_0);
                if (a > 25'(NLIM)) pm_error(pnm_pkg::E_BIGNUM);
                else pm_acc = a[20:0];
                return;
            end
            was_hdr = (pm_phase == pnm_pkg::PH_HEADER);
            pm_finish();
            if (pm_phase == pnm_pkg::PH_ERROR || pm_phase == pnm_pkg::PH_DONE) return;
            if (was_hdr && pm_phase == pnm_pkg::PH_BODY) begin
                if (b == pnm_pkg::CH_CR) pm_phase = pnm_pkg::PH_AFTER_CR;
                return;
            end
        end
        if (sp) return;
        if (b == pnm_pkg::CH_HASH) begin pm_incom = 1'b1; return; end
        if (dig) begin pm_innum = 1'b1; pm_acc = 21'(b - pnm_pkg::CH_0); return; end
        pm_error(pnm_pkg::E_CHAR);
    endfunction

    function automatic void pm_bits(logic [7:0] b);
        logic [7:0] v;
        for (int k = 0; k < 8; k++) begin
            if (pm_col < pm_w) begin
                v = b[7-k] ? 8'd0 : 8'd255;
                push_word(pnm_pkg::K_PIX, '0, '0, '0, '0, pm_col, pm_row, v, v, v);
                pm_col = pm_col + 17'd1;
            end
        end
        if (pm_col >= pm_w) pm_row_end();
    endfunction

    function automatic void pm_body(logic [7:0] b);
        if (pm_fmt == pnm_pkg::FMT_P4) pm_bits(b);
        else pm_text(b);
    endfunction

    function automatic void predict_word(logic [7:0] b, logic eof);
        int first;
        first = pixel_words.size();
        produced = 0;
        if (eof) begin
            if ((pm_phase == pnm_pkg::PH_HEADER || pm_phase == pnm_pkg::PH_BODY) && pm_innum)
                pm_finish();
            if (pm_phase != pnm_pkg::PH_DONE && pm_phase != pnm_pkg::PH_ERROR)
                pm_error(pnm_pkg::E_TRUNC);
            pm_clear();
        end else begin
            case (pm_phase)
                pnm_pkg::PH_WAIT_P: begin
                    if (b == pnm_pkg::CH_P) pm_phase = pnm_pkg::PH_WAIT_D;
                    else pm_error(pnm_pkg::E_MAGIC);
                end
                pnm_pkg::PH_WAIT_D: begin
                    if (b >= pnm_pkg::CH_1 && b <= pnm_pkg::CH_4) begin
                        pm_fmt = 2'(b - pnm_pkg::CH_1);
                        pm_phase = pnm_pkg::PH_HEADER;
                    end else pm_error(pnm_pkg::E_MAGIC);
                end
                pnm_pkg::PH_HEADER: pm_text(b);
                pnm_pkg::PH_AFTER_CR: begin
                    pm_phase = pnm_pkg::PH_BODY;
                    if (b != pnm_pkg::CH_LF) pm_body(b);
                end
                pnm_pkg::PH_BODY: pm_body(b);
                default: ;
            endcase
        end
        if (pixel_words.size() > first) pixel_words[pixel_words.size()-1].last = 1'b1;
    endfunction

    // stimulus builders
    function automatic void put_word(logic [8:0] x);
        byte_queue.push_back(x);
        added++;
    endfunction

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++) put_word({1'b0, s[i]});
    endfunction

    function automatic void put_eof();
        put_word({1'b1, 8'($urandom)});
    endfunction

    function automatic string sep();
        case ($urandom_range(0, 5))
            0: return "\t";
            1: return "\n";
            2: return " # note\n";
            3: return "\r\n";
            default: return " ";
        endcase
    endfunction

    function automatic void random_file();
        int f, w, h, mx, n, k;
        string s;
        f = $urandom_range(1, 4);
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 5);
        h = $urandom_range(1, 3);
        mx = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(1, 255);
        s = $sformatf("P%0d%s%0d%s%0d", f, sep(), w, sep(), h);
        if (f == 2 || f == 3) s = {s, $sformatf("%s%0d", sep(), mx)};
        if ($urandom_range(0, 1) != 0) s = {s, "\r\n"};
        else s = {s, " "};
        put_str(s);
        if (f == 4) begin
            n = ((w + 7) / 8) * h;
            for (k = 0; k < n; k++) put_word({1'b0, 8'($urandom)});
        end else begin
            n = w * h * ((f == 3) ? 3 : 1);
            if ($urandom_range(0, 4) == 0) n = $urandom_range(0, n);
            for (k = 0; k < n; k++) begin
                if (f == 1) s = $sformatf("%0d", $urandom_range(0, 1));
                else s = $sformatf("%0d", ($urandom_range(0, 3) == 0)
                                   ? $urandom_range(0, 999) : $urandom_range(0, mx));
                put_str({s, sep()});
            end
        end
        if ($urandom_range(0, 5) == 0) put_word({1'b0, 8'($urandom)});
        put_eof();
    endfunction

    // driver
    int cycles, stall_left;
    logic tx_idle_en, rx_idle_en;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid) predict_word(in_ch.data_byte, in_ch.end_of_file);
            if (byte_queue.size() > 0 && !(tx_idle_en && $urandom_range(0, 99) < 32)) begin
                in_ch.valid <= 1'b1;
                {in_ch.end_of_file, in_ch.data_byte} <= byte_queue.pop_front();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // long receiver hold off
    logic hold_off;
    always @(posedge i_clk) begin
        if (!i_rst_n) stall_left <= 0;
        else if (stall_left > 0) stall_left <= stall_left - 1;
        else if (hold_off) stall_left <= 300;
    end

    // monitor
    always @(posedge i_clk) begin
        tb_pnm_types::t_expect e;
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                received++;
                if (pixel_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected word kind %0d", out_ch.result_kind);
                end else begin
                    e = pixel_words.pop_front();
                    if ({out_ch.result_kind, out_ch.error_code, out_ch.image_width,
                         out_ch.image_height, out_ch.channel_count, out_ch.pixel_column,
                         out_ch.pixel_row, out_ch.red, out_ch.green, out_ch.blue,
                         out_ch.last_result} !== e) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch exp k%0d e%0d w%0d h%0d c%0d x%0d y%0d %s",
                                e.kind, e.err, e.w, e.h, e.ch, e.col, e.row,
                                $sformatf("rgb %0d %0d %0d l%0d", e.r, e.g, e.b, e.last));
                            $display("         got k%0d e%0d w%0d h%0d c%0d x%0d y%0d %s",
                                out_ch.result_kind, out_ch.error_code,
                                out_ch.image_width, out_ch.image_height,
                                out_ch.channel_count, out_ch.pixel_column, out_ch.pixel_row,
                                $sformatf("rgb %0d %0d %0d l%0d", out_ch.red,
                                          out_ch.green, out_ch.blue, out_ch.last_result));
                        end
                    end
                end
            end
            if (stall_left > 0 || hold_off) begin
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= !(rx_idle_en && $urandom_range(0, 99) < 32);
            end
        end
    end

    initial begin
        mismatches = 0; received = 0; cycles = 0; hold_off = 1'b0; added = 0;
        stim_done = 1'b0; tx_idle_en = 1'b1; rx_idle_en = 1'b1;
        i_rst_n = 1'b0;
        in_ch.valid = 0; in_ch.data_byte = 0; in_ch.end_of_file = 0; out_ch.ready = 0;
        pm_clear();
        // directed: every format, errors, eof cases
        put_str("P1 2 1\n1 0 "); put_eof();
        put_str("P4\n9 1\r\n"); put_word(9'h0FF); put_word(9'h000);
        put_eof();
        put_str("P2 1 1 255\r\n255"); put_eof();
        put_str("P3 1 1 3 0 1 7 "); put_eof();
        put_eof();
        put_str("Q"); put_eof();
        put_str("P7"); put_eof();
        put_str("P1 2 x"); put_eof();
        put_str("P2 1048577"); put_eof();
        put_str("P1 0 "); put_eof();
        put_str("P2 1 1 256 "); put_eof();
        put_str("P1 100001 "); put_eof();
        put_str("P2 2 1 1 1"); put_eof();
        while (added < 200) random_file();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // long receiver stall with the sender busy
        repeat (20) @(posedge i_clk);
        hold_off <= 1'b1;
        @(posedge i_clk);
        hold_off <= 1'b0;
        while (byte_queue.size() > 0) @(posedge i_clk);
        // stretch with no idling on either side
        tx_idle_en <= 1'b0; rx_idle_en <= 1'b0;
        do random_file(); while (added < 280);
        while (byte_queue.size() > 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        tx_idle_en <= 1'b1; rx_idle_en <= 1'b1;
        do random_file(); while (added < 330);
        stim_done <= 1'b1;
    end

    initial begin
        @(posedge i_clk);
        while (!stim_done || byte_queue.size() > 0 || in_ch.valid || pixel_words.size() > 0
               || stall_left > 0) begin
            @(posedge i_clk);
            if (cycles > CYCLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && pixel_words.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/pnm_pkg.sv
rtl/pnm_if.sv
rtl/pnm_front.sv
rtl/pnm_queue.sv
rtl/pnm_div.sv
rtl/pnm_back.sv
rtl/pnm_bitmap_graymap_pixmap_decoder.sv
rtl/pnm_chk.sv
tb/tb_pnm_if.sv
tb/tb_pnm_bitmap_graymap_pixmap_decoder.sv
